// ===== hdl/tccw_pkg.sv =====
`default_nettype none

package tccw_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 24;
  localparam int TAB_STOP       = 8;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  // Internal widths
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int CELL_W = $clog2(CELL_COUNT);
  // Tab target can run one column past the last column
  localparam int TAB_W  = $clog2(SCREEN_COLUMNS + TAB_STOP);

  // Port field widths
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int IN_ROW_W   = 5;
  localparam int IN_COL_W   = 7;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_OFF_W  = 11;
  localparam int CELL_VAL_W = ATTR_W + CODE_W;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Character codes
  localparam logic [CODE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Next tab stop for every column, built at elaboration
  typedef logic [TAB_W-1:0] tab_stop_t;
  typedef tab_stop_t [SCREEN_COLUMNS-1:0] tab_tbl_t;

  function automatic tab_tbl_t build_tab_next();
    tab_tbl_t t;
    int stop;
    stop = TAB_STOP;
    for (int c = 0; c < SCREEN_COLUMNS; c++) begin
      if (c == stop) begin
        stop = stop + TAB_STOP;
      end
      t[c] = TAB_W'(stop);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_NEXT = build_tab_next();

endpackage

`default_nettype wire

// ===== hdl/text_console_char_writer.sv =====
// Each item passes S_ADDR and S_EXEC (reads also S_RDATA) to S_RESULT, which loads the result.
// A scroll adds an S_BLANK sweep of one row, a clear adds an S_CLEAR sweep of every cell,
//   and a stalled result holds off the next input; in_stall is high until the item is done.
// Scrolling rotates a top-row pointer, so only the new bottom row is rewritten.
// Reset (rst_n low, synchronous): cursor home, attribute 0x0F, then a pass over all CELL_COUNT
//   (1920) cells writes 0x0F20 to each; in_stall stays high during that pass.
`default_nettype none

module text_console_char_writer
  import tccw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [ATTR_W-1:0]     cfg_wr_data,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [CODE_W-1:0]     in_char_code,
  input  wire logic [IN_ROW_W-1:0]   in_read_row,
  input  wire logic [IN_COL_W-1:0]   in_read_col,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_COL_W-1:0]       out_cursor_col,
  output logic [OUT_ROW_W-1:0]       out_cursor_row,
  output logic [OUT_OFF_W-1:0]       out_cursor_offset,
  output logic                       out_scrolled,
  output logic [CELL_VAL_W-1:0]      out_cell_value
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ADDR   = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_RDATA  = 8'b0001_0000,
    S_BLANK  = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  // control registers
  state_t                state_r, state_nxt;
  logic [ATTR_W-1:0]     attr_r, attr_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [ROW_W-1:0]      top_r, top_nxt;
  logic [CELL_W-1:0]     sweep_addr_r, sweep_addr_nxt;
  logic [COL_W-1:0]      sweep_col_r, sweep_col_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload registers
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic [IN_ROW_W-1:0]   rrow_r, rrow_nxt;
  logic [IN_COL_W-1:0]   rcol_r, rcol_nxt;
  logic [ROW_W-1:0]      phys_row_r, phys_row_nxt;
  logic [COL_W-1:0]      col_sel_r, col_sel_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic                  scrolled_r, scrolled_nxt;
  logic [CELL_VAL_W-1:0] cell_r, cell_nxt;
  logic [OUT_COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [OUT_OFF_W-1:0]  out_off_r, out_off_nxt;
  logic                  out_scr_r, out_scr_nxt;
  logic [CELL_VAL_W-1:0] out_cell_r, out_cell_nxt;

  // screen memory
  logic [CELL_VAL_W-1:0] screen_mem [CELL_COUNT];
  logic [CELL_VAL_W-1:0] rd_data_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [CELL_W-1:0]     mem_addr;
  logic [CELL_VAL_W-1:0] mem_wdata;

  // datapath helpers
  logic                  in_xfer;
  logic [ROW_W-1:0]      row_sel;
  logic [ROW_W:0]        row_sum;
  logic [TAB_W-1:0]      col_ext;
  logic [TAB_W-1:0]      next_col;
  logic                  line_inc;
  logic                  do_scroll;
  logic [CELL_W-1:0]     cell_addr;
  logic [CELL_W-1:0]     cursor_off;
  logic [CELL_VAL_W-1:0] blank_cell;

  assign in_xfer    = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign blank_cell = {attr_r, BLANK_CHAR};

  // logical row plus top pointer, wrapped once
  always_comb begin
    row_sel = (kind_r == KIND_READ) ? ROW_W'(rrow_r) : row_r;
    row_sum = {1'b0, row_sel} + {1'b0, top_r};
    if (int'(row_sum) >= SCREEN_ROWS) begin
      phys_row_nxt = ROW_W'(row_sum - (ROW_W + 1)'(SCREEN_ROWS));
    end else begin
      phys_row_nxt = ROW_W'(row_sum);
    end
    col_sel_nxt = (kind_r == KIND_READ) ? COL_W'(rcol_r) : col_r;
    rd_ok_nxt   = (int'(rrow_r) < SCREEN_ROWS) && (int'(rcol_r) < SCREEN_COLUMNS);
  end

  // cursor movement for a put item
  always_comb begin
    col_ext  = TAB_W'(col_r);
    next_col = col_ext;
    line_inc = 1'b0;
    case (code_r)
      CHAR_BS: begin
        if (col_r != '0) begin
          next_col = col_ext - TAB_W'(1);
        end
      end
      CHAR_TAB: begin
        next_col = TAB_NEXT[col_r];
      end
      CHAR_CR: begin
        next_col = '0;
      end
      CHAR_LF: begin
        next_col = '0;
        line_inc = 1'b1;
      end
      default: begin
        if (code_r >= BLANK_CHAR) begin
          next_col = col_ext + TAB_W'(1);
        end
      end
    endcase
    // wrap past the last column
    if (int'(next_col) >= SCREEN_COLUMNS) begin
      next_col = '0;
      line_inc = 1'b1;
    end
    do_scroll = line_inc && (row_r == ROW_W'(SCREEN_ROWS - 1));
  end

  assign cell_addr  = CELL_W'(phys_row_r) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(col_sel_r);
  assign cursor_off = CELL_W'(row_r) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(col_r);

  // main sequencer
  always_comb begin
    state_nxt      = state_r;
    attr_nxt       = cfg_wr_en ? cfg_wr_data : attr_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    top_nxt        = top_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_col_nxt  = sweep_col_r;
    out_valid_nxt  = out_valid_r && out_stall;
    kind_nxt       = kind_r;
    code_nxt       = code_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    scrolled_nxt   = scrolled_r;
    cell_nxt       = cell_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_off_nxt    = out_off_r;
    out_scr_nxt    = out_scr_r;
    out_cell_nxt   = out_cell_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = cell_addr;
    mem_wdata      = {attr_r, code_r};

    case (state_r)
      S_INIT: begin
        mem_we         = 1'b1;
        mem_addr       = sweep_addr_r;
        mem_wdata      = {RESET_ATTR, BLANK_CHAR};
        sweep_addr_nxt = sweep_addr_r + CELL_W'(1);
        if (sweep_addr_r == CELL_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt     = in_kind;
          code_nxt     = in_char_code;
          rrow_nxt     = in_read_row;
          rcol_nxt     = in_read_col;
          scrolled_nxt = 1'b0;
          cell_nxt     = '0;
          state_nxt    = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (kind_r)
          KIND_PUT: begin
            mem_we  = (code_r >= BLANK_CHAR);
            col_nxt = COL_W'(next_col);
            if (do_scroll) begin
              // old top row becomes the new bottom row
              top_nxt        = (top_r == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_r + ROW_W'(1);
              sweep_addr_nxt = CELL_W'(top_r) * CELL_W'(SCREEN_COLUMNS);
              sweep_col_nxt  = '0;
              scrolled_nxt   = 1'b1;
              state_nxt      = S_BLANK;
            end else begin
              if (line_inc) begin
                row_nxt = row_r + ROW_W'(1);
              end
              state_nxt = S_RESULT;
            end
          end
          KIND_CLEAR: begin
            col_nxt        = '0;
            row_nxt        = '0;
            top_nxt        = '0;
            sweep_addr_nxt = '0;
            state_nxt      = S_CLEAR;
          end
          KIND_READ: begin
            mem_re    = rd_ok_r;
            state_nxt = S_RDATA;
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_RDATA: begin
        cell_nxt  = rd_ok_r ? rd_data_r : '0;
        state_nxt = S_RESULT;
      end
      S_BLANK: begin
        mem_we         = 1'b1;
        mem_addr       = sweep_addr_r;
        mem_wdata      = blank_cell;
        sweep_addr_nxt = sweep_addr_r + CELL_W'(1);
        sweep_col_nxt  = sweep_col_r + COL_W'(1);
        if (sweep_col_r == COL_W'(SCREEN_COLUMNS - 1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_addr       = sweep_addr_r;
        mem_wdata      = blank_cell;
        sweep_addr_nxt = sweep_addr_r + CELL_W'(1);
        if (sweep_addr_r == CELL_W'(CELL_COUNT - 1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = OUT_COL_W'(col_r);
          out_row_nxt   = OUT_ROW_W'(row_r);
          out_off_nxt   = OUT_OFF_W'(cursor_off);
          out_scr_nxt   = scrolled_r;
          out_cell_nxt  = cell_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      attr_r       <= RESET_ATTR;
      col_r        <= '0;
      row_r        <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_col_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      attr_r       <= attr_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_col_r  <= sweep_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    code_r     <= code_nxt;
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    phys_row_r <= phys_row_nxt;
    col_sel_r  <= col_sel_nxt;
    rd_ok_r    <= rd_ok_nxt;
    scrolled_r <= scrolled_nxt;
    cell_r     <= cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_off_r  <= out_off_nxt;
    out_scr_r  <= out_scr_nxt;
    out_cell_r <= out_cell_nxt;
  end

  // screen memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= screen_mem[mem_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_scrolled      = out_scr_r;
  assign out_cell_value    = out_cell_r;

endmodule

`default_nettype wire

// ===== hdl/tccw_checker.sv =====
`default_nettype none

module tccw_checker
  import tccw_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [OUT_COL_W-1:0]  out_cursor_col,
  input wire logic [OUT_ROW_W-1:0]  out_cursor_row,
  input wire logic [OUT_OFF_W-1:0]  out_cursor_offset,
  input wire logic                  out_scrolled,
  input wire logic [CELL_VAL_W-1:0] out_cell_value
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < SCREEN_COLUMNS) &&
                  (int'(out_cursor_row) < SCREEN_ROWS))
    else $error("cursor off screen");

  // offset agrees with row and column
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_offset) ==
                   ((int'(out_cursor_row) * SCREEN_COLUMNS + int'(out_cursor_col)) &
                    ((1 << OUT_OFF_W) - 1))))
    else $error("cursor offset mismatch");

  // a scroll leaves the cursor on the last row and returns no cell
  a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      (int'(out_cursor_row) == SCREEN_ROWS - 1) && (out_cell_value == '0))
    else $error("scroll result inconsistent");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cursor_col    (out_cursor_col),
  .out_cursor_row    (out_cursor_row),
  .out_cursor_offset (out_cursor_offset),
  .out_scrolled      (out_scrolled),
  .out_cell_value    (out_cell_value)
);

`default_nettype wire

// ===== verif/tb_text_console_char_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_char_writer;
  import tccw_pkg::*;

  // Kind 3 is not decoded by the block; the cursor is reported unchanged
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_IDLE = 13;
  localparam int SETTLE_CYCLES = 16;
  localparam longint TIMEOUT_NS = 64'd40_000_000;

  typedef struct packed {
    logic [OUT_COL_W-1:0]  col;
    logic [OUT_ROW_W-1:0]  row;
    logic [OUT_OFF_W-1:0]  offset;
    logic                  scrolled;
    logic [CELL_VAL_W-1:0] cell_value;
  } console_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [ATTR_W-1:0]     cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind;
  logic [CODE_W-1:0]     in_char_code;
  logic [IN_ROW_W-1:0]   in_read_row;
  logic [IN_COL_W-1:0]   in_read_col;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_COL_W-1:0]  out_cursor_col;
  logic [OUT_ROW_W-1:0]  out_cursor_row;
  logic [OUT_OFF_W-1:0]  out_cursor_offset;
  logic                  out_scrolled;
  logic [CELL_VAL_W-1:0] out_cell_value;

  // Mirror of the console state
  logic [CELL_VAL_W-1:0] screen_mirror [CELL_COUNT];
  int                    cursor_col_q;
  int                    cursor_row_q;
  logic [ATTR_W-1:0]     attr_mirror;

  console_result_t       expected_results [$];
  console_result_t       want_result;
  int                    mismatch_count = 0;
  bit                    steady_flow = 1'b0;

  text_console_char_writer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled),
    .out_cell_value    (out_cell_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, wanted);
    mismatch_count++;
  endtask

  function automatic void blank_mirror();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_mirror[i] = {attr_mirror, BLANK_CHAR};
    end
  endfunction

  // Applies one item to the mirror and returns the result it should produce
  function automatic console_result_t console_step(input logic [KIND_W-1:0] kind,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic [IN_ROW_W-1:0] rrow,
                                                   input logic [IN_COL_W-1:0] rcol);
    console_result_t res;
    logic did_scroll;
    logic [CELL_VAL_W-1:0] cell_word;
    did_scroll = 1'b0;
    cell_word = '0;
    if (kind == KIND_PUT) begin
      if (code == CHAR_BS) begin
        if (cursor_col_q != 0) cursor_col_q--;
      end else if (code == CHAR_TAB) begin
        cursor_col_q = cursor_col_q - (cursor_col_q % TAB_STOP) + TAB_STOP;
      end else if (code == CHAR_CR) begin
        cursor_col_q = 0;
      end else if (code == CHAR_LF) begin
        cursor_col_q = 0;
        cursor_row_q++;
      end else if (code >= BLANK_CHAR) begin
        screen_mirror[cursor_row_q * SCREEN_COLUMNS + cursor_col_q] = {attr_mirror, code};
        cursor_col_q++;
      end
      // wrap past the last column
      if (cursor_col_q >= SCREEN_COLUMNS) begin
        cursor_col_q = 0;
        cursor_row_q++;
      end
      // scroll up one row, new bottom row takes the current attribute
      if (cursor_row_q >= SCREEN_ROWS) begin
        for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++) begin
          screen_mirror[i] = screen_mirror[i + SCREEN_COLUMNS];
        end
        for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++) begin
          screen_mirror[i] = {attr_mirror, BLANK_CHAR};
        end
        cursor_row_q = SCREEN_ROWS - 1;
        did_scroll = 1'b1;
      end
    end else if (kind == KIND_CLEAR) begin
      blank_mirror();
      cursor_col_q = 0;
      cursor_row_q = 0;
    end else if (kind == KIND_READ) begin
      if (rrow < SCREEN_ROWS && rcol < SCREEN_COLUMNS) begin
        cell_word = screen_mirror[rrow * SCREEN_COLUMNS + rcol];
      end
    end
    res.col        = OUT_COL_W'(cursor_col_q);
    res.row        = OUT_ROW_W'(cursor_row_q);
    res.offset     = OUT_OFF_W'(cursor_row_q * SCREEN_COLUMNS + cursor_col_q);
    res.scrolled   = did_scroll;
    res.cell_value = cell_word;
    return res;
  endfunction

  // One input transfer; in_valid stays high when the next item follows at once
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [IN_ROW_W-1:0] rrow, input logic [IN_COL_W-1:0] rcol);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_char_code <= code;
    in_read_row  <= rrow;
    in_read_col  <= rcol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(console_step(kind, code, rrow, rcol));
  endtask

  task automatic put_char(input logic [CODE_W-1:0] code);
    send_item(KIND_PUT, code, IN_ROW_W'($urandom), IN_COL_W'($urandom));
  endtask

  task automatic read_cell(input logic [IN_ROW_W-1:0] rrow, input logic [IN_COL_W-1:0] rcol);
    send_item(KIND_READ, CODE_W'($urandom), rrow, rcol);
  endtask

  // Drain all results, let the block finish any sweep
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_text_attribute(input logic [ATTR_W-1:0] attr);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    attr_mirror = attr;
  endtask

  // Result side: stall for a random number of cycles after each transfer
  initial begin : result_stall_gen
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
        hold = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
        if (hold != 0) out_stall <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_cursor_offset, 0);
      end else begin
        want_result = expected_results.pop_front();
        if (out_cursor_col !== want_result.col)
          report_mismatch("cursor_col", out_cursor_col, want_result.col);
        if (out_cursor_row !== want_result.row)
          report_mismatch("cursor_row", out_cursor_row, want_result.row);
        if (out_cursor_offset !== want_result.offset)
          report_mismatch("cursor_offset", out_cursor_offset, want_result.offset);
        if (out_scrolled !== want_result.scrolled)
          report_mismatch("scrolled", out_scrolled, want_result.scrolled);
        if (out_cell_value !== want_result.cell_value)
          report_mismatch("cell_value", out_cell_value, want_result.cell_value);
      end
    end
  end

  // Screen comes up blank with the reset attribute
  task automatic test_reset_contents();
    read_cell(5'd0, 7'd0);
    read_cell(IN_ROW_W'(SCREEN_ROWS - 1), IN_COL_W'(SCREEN_COLUMNS - 1));
  endtask

  // Printable range ends, including bytes at and above 0x7F
  task automatic test_printable_bytes();
    put_char(BLANK_CHAR);
    put_char(8'h7E);
    put_char(8'h7F);
    put_char(8'hFF);
    read_cell(5'd0, 7'd3);
  endtask

  // Backspace, tab, CR, LF and ignored control bytes
  task automatic test_cursor_controls();
    put_char(CHAR_BS);
    put_char(CHAR_CR);
    put_char(CHAR_BS);
    put_char(CHAR_TAB);
    put_char(8'h41);
    put_char(CHAR_TAB);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(CHAR_LF);
  endtask

  // Reads outside the screen and the undecoded kind
  task automatic test_read_bounds_and_unused();
    read_cell(IN_ROW_W'(SCREEN_ROWS), 7'd0);
    read_cell(5'h1F, 7'h7F);
    read_cell(5'd0, IN_COL_W'(SCREEN_COLUMNS));
    send_item(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    send_item(KIND_UNUSED, 8'h00, 5'h00, 7'h00);
  endtask

  // Clear blanks with the attribute in force
  task automatic test_attribute_and_clear();
    write_text_attribute(8'h00);
    put_char(8'h55);
    send_item(KIND_CLEAR, 8'h00, 5'h00, 7'h00);
    read_cell(5'd0, 7'd0);
    read_cell(IN_ROW_W'(SCREEN_ROWS - 1), IN_COL_W'(SCREEN_COLUMNS - 1));
  endtask

  // Walk to the bottom row, then tab past the last stop to wrap and scroll
  task automatic test_tab_wrap_and_scroll();
    write_text_attribute(8'hFF);
    for (int i = 0; i < SCREEN_ROWS - 1; i++) put_char(CHAR_LF);
    put_char(8'h58);
    for (int i = 0; i < SCREEN_COLUMNS / TAB_STOP; i++) put_char(CHAR_TAB);
    read_cell(IN_ROW_W'(SCREEN_ROWS - 2), 7'd0);
    read_cell(IN_ROW_W'(SCREEN_ROWS - 1), 7'd5);
  endtask

  // Mostly text with line control, reads near the cursor, rare clears and noise
  task automatic test_random_traffic(input int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) put_char(CODE_W'($urandom_range(32, 126)));
      else if (pick < 55) put_char(CODE_W'($urandom_range(127, 255)));
      else if (pick < 65) put_char(CHAR_LF);
      else if (pick < 69) put_char(CHAR_CR);
      else if (pick < 75) put_char(CHAR_TAB);
      else if (pick < 79) put_char(CHAR_BS);
      else if (pick < 82) put_char(CODE_W'($urandom_range(0, 31)));
      else if (pick < 88) read_cell(IN_ROW_W'(cursor_row_q),
                                    IN_COL_W'($urandom_range(0, SCREEN_COLUMNS - 1)));
      else if (pick < 93) read_cell(IN_ROW_W'($urandom_range(0, SCREEN_ROWS - 1)),
                                    IN_COL_W'($urandom_range(0, SCREEN_COLUMNS - 1)));
      else if (pick < 96) read_cell(IN_ROW_W'($urandom), IN_COL_W'($urandom));
      else if (pick < 98) send_item(KIND_CLEAR, CODE_W'($urandom), IN_ROW_W'($urandom),
                                    IN_COL_W'($urandom));
      else send_item(KIND_UNUSED, CODE_W'($urandom), IN_ROW_W'($urandom),
                     IN_COL_W'($urandom));
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_PUT;
    in_char_code <= '0;
    in_read_row  <= '0;
    in_read_col  <= '0;
    attr_mirror  = RESET_ATTR;
    blank_mirror();
    cursor_col_q = 0;
    cursor_row_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_printable_bytes();
    test_cursor_controls();
    test_read_bounds_and_unused();
    test_attribute_and_clear();
    test_tab_wrap_and_scroll();

    write_text_attribute(8'h00);
    test_random_traffic(105);
    write_text_attribute(8'hFF);
    steady_flow = 1'b1;
    test_random_traffic(105);
    write_text_attribute(ATTR_W'($urandom_range(1, 254)));
    steady_flow = 1'b0;
    test_random_traffic(110);
    write_text_attribute(ATTR_W'($urandom_range(1, 254)));
    test_random_traffic(110);

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
